// File: rtl/core/pdc_pkg.sv
// -----------------------------------------------------------------------------
// pdc_pkg
// Shared types, letter codes and lookup helpers for the Playfair digraph cipher.
// -----------------------------------------------------------------------------
package pdc_pkg;

    localparam int GRID   = 5;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef logic [4:0] t_letter;
    typedef logic [2:0] t_coord;
    typedef logic [1:0] t_cfg_idx;

    localparam t_letter LET_I = 5'd8;
    localparam t_letter LET_J = 5'd9;
    localparam t_letter LET_Q = 5'd16;
    localparam t_letter LET_X = 5'd23;
    localparam t_letter LET_Z = 5'd25;

    localparam t_cfg_idx CFG_MODE      = 2'd0;
    localparam t_cfg_idx CFG_SQ_FIRST  = 2'd1;
    localparam t_cfg_idx CFG_SQ_SECOND = 2'd2;
    localparam t_cfg_idx CFG_SQ_FINAL  = 2'd3;

    // Key square indexed [row][column], each cell a letter code.
    typedef logic [GRID-1:0][GRID-1:0][4:0] t_square;

    // One unit of work for the back end: a pair to substitute, or a single
    // letter to pass through. last marks the final result of the input item.
    typedef struct packed {
        t_letter a;
        t_letter b;
        logic    single;
        logic    last;
    } t_job;

    typedef struct packed {
        logic   ok;
        t_coord row;
        t_coord col;
    } t_loc;

    // Finds the lowest-numbered cell holding the letter.
    function automatic t_loc locate(t_square sq, t_letter l);
        t_loc res;
        res = '0;
        for (int r = GRID - 1; r >= 0; r--) begin
            for (int c = GRID - 1; c >= 0; c--) begin
                if (sq[r][c] == l) begin
                    res.ok  = 1'b1;
                    res.row = t_coord'(r);
                    res.col = t_coord'(c);
                end
            end
        end
        return res;
    endfunction

    // Moves one place right/down when encrypting, left/up when decrypting.
    function automatic t_coord step_coord(t_coord x, logic dec);
        t_coord res;
        if (dec) begin
            res = (x == '0) ? t_coord'(GRID - 1) : t_coord'(x - 3'd1);
        end else begin
            res = (x == t_coord'(GRID - 1)) ? '0 : t_coord'(x + 3'd1);
        end
        return res;
    endfunction

endpackage

// File: rtl/core/pdc_front.sv
// -----------------------------------------------------------------------------
// pdc_front
// Accepts letters, keeps the pending first letter of a pair, and turns each
// item into zero, one or two jobs for the back end.
// -----------------------------------------------------------------------------
module pdc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mode,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pdc_pkg::t_letter i_letter,
    input  logic             i_text_end,
    output logic             o_push,
    output pdc_pkg::t_job    o_job,
    input  logic             i_full
);

    logic             r_pend_v, n_pend_v;
    pdc_pkg::t_letter r_pend_l, n_pend_l;
    logic             r_hold_v;
    pdc_pkg::t_job    r_hold;

    logic             w_accept;
    pdc_pkg::t_letter w_cin;
    logic             w_j1_v, w_j2_v;
    pdc_pkg::t_job    w_j1, w_j2, w_pad;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = !r_hold_v && !i_full;
    assign w_cin      = (!i_mode && i_letter == pdc_pkg::LET_J) ? pdc_pkg::LET_I : i_letter;

    always_comb begin
        n_pend_v = r_pend_v;
        n_pend_l = r_pend_l;
        w_j1_v   = 1'b0;
        w_j2_v   = 1'b0;
        w_j1     = '0;
        w_j2     = '0;
        w_pad    = '0;
        if (!i_mode) begin
            if (r_pend_v) begin
                w_j1_v = 1'b1;
                if (r_pend_l == w_cin) begin
                    // Repeated letter: split with a filler, the new letter waits.
                    w_j1.a = r_pend_l;
                    w_j1.b = (r_pend_l == pdc_pkg::LET_X) ? pdc_pkg::LET_Q : pdc_pkg::LET_X;
                end else begin
                    w_j1.a   = r_pend_l;
                    w_j1.b   = w_cin;
                    n_pend_v = 1'b0;
                end
            end else begin
                n_pend_v = 1'b1;
                n_pend_l = w_cin;
            end
            if (i_text_end && n_pend_v) begin
                w_pad.a  = n_pend_l;
                w_pad.b  = (n_pend_l == pdc_pkg::LET_Z) ? pdc_pkg::LET_X : pdc_pkg::LET_Z;
                n_pend_v = 1'b0;
                if (w_j1_v) begin
                    w_j2   = w_pad;
                    w_j2_v = 1'b1;
                end else begin
                    w_j1   = w_pad;
                    w_j1_v = 1'b1;
                end
            end
        end else begin
            if (r_pend_v) begin
                w_j1_v   = 1'b1;
                w_j1.a   = r_pend_l;
                w_j1.b   = i_letter;
                n_pend_v = 1'b0;
            end else begin
                n_pend_v = 1'b1;
                n_pend_l = i_letter;
            end
            if (i_text_end && n_pend_v) begin
                w_j1_v      = 1'b1;
                w_j1.a      = n_pend_l;
                w_j1.single = 1'b1;
                n_pend_v    = 1'b0;
            end
        end
        w_j1.last = !w_j2_v;
        w_j2.last = 1'b1;
    end

    assign o_push = r_hold_v ? !i_full : (w_accept && w_j1_v);
    assign o_job  = r_hold_v ? r_hold : w_j1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_pend_l <= '0;
            r_hold_v <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pend_v <= n_pend_v;
                r_pend_l <= n_pend_l;
            end
            if (w_accept && w_j2_v) begin
                r_hold_v <= 1'b1;
            end else if (r_hold_v && !i_full) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_j2_v) begin
            r_hold <= w_j2;
        end
    end

endmodule

// File: rtl/core/pdc_queue.sv
// -----------------------------------------------------------------------------
// pdc_queue
// Short job queue between the front and back ends.
// -----------------------------------------------------------------------------
module pdc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pdc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pdc_pkg::t_job o_job
);

    pdc_pkg::t_job              r_mem [pdc_pkg::QDEPTH];
    logic [pdc_pkg::QAW-1:0]    r_wr_ptr;
    logic [pdc_pkg::QAW-1:0]    r_rd_ptr;
    logic [pdc_pkg::QAW:0]      r_count;

    assign o_full  = (r_count == (pdc_pkg::QAW+1)'(pdc_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("job queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (pdc_pkg::QAW+1)'(pdc_pkg::QDEPTH)) else $error("job queue count out of range");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr)) else $error("empty queue with unequal pointers");

endmodule

// File: rtl/core/pdc_back.sv
// -----------------------------------------------------------------------------
// pdc_back
// Looks up each job in the key square, substitutes the pair, and hands the
// resulting letters out one per cycle while the output side is ready.
// -----------------------------------------------------------------------------
module pdc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_mode,
    input  pdc_pkg::t_square  i_square,
    input  logic              i_job_valid,
    output logic              o_pop,
    input  pdc_pkg::t_job     i_job,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pdc_pkg::t_letter  o_out_letter,
    output logic              o_out_last
);

    // Stage 1: job taken from the queue.
    logic             r_s1_v;
    pdc_pkg::t_job    r_s1;
    // Stage 2: cell positions found.
    logic             r_s2_v;
    logic             r_s2_single;
    logic             r_s2_last;
    pdc_pkg::t_letter r_s2_a, r_s2_b;
    pdc_pkg::t_loc    r_s2_la, r_s2_lb;
    // Output buffer: up to two letters.
    logic             r_ob_v;
    logic             r_ob_two;
    logic             r_ob_sel;
    logic             r_ob_last;
    pdc_pkg::t_letter r_ob_l0, r_ob_l1;

    logic             w_ob_free, w_s2_load, w_s1_load;
    pdc_pkg::t_letter w_a_m, w_b_m, n_l0, n_l1;

    assign w_ob_free = !r_ob_v || (i_out_ready && (!r_ob_two || r_ob_sel));
    assign w_s2_load = !r_s2_v || w_ob_free;
    assign w_s1_load = !r_s1_v || w_s2_load;
    assign o_pop     = i_job_valid && w_s1_load;

    // J is looked up as I in both modes; a passed-through single stays raw.
    assign w_a_m = (!r_s1.single && r_s1.a == pdc_pkg::LET_J) ? pdc_pkg::LET_I : r_s1.a;
    assign w_b_m = (r_s1.b == pdc_pkg::LET_J) ? pdc_pkg::LET_I : r_s1.b;

    always_comb begin
        n_l0 = r_s2_a;
        n_l1 = r_s2_b;
        if (!r_s2_single && r_s2_la.ok && r_s2_lb.ok) begin
            if (r_s2_la.row == r_s2_lb.row) begin
                n_l0 = i_square[r_s2_la.row][pdc_pkg::step_coord(r_s2_la.col, i_mode)];
                n_l1 = i_square[r_s2_lb.row][pdc_pkg::step_coord(r_s2_lb.col, i_mode)];
            end else if (r_s2_la.col == r_s2_lb.col) begin
                n_l0 = i_square[pdc_pkg::step_coord(r_s2_la.row, i_mode)][r_s2_la.col];
                n_l1 = i_square[pdc_pkg::step_coord(r_s2_lb.row, i_mode)][r_s2_lb.col];
            end else begin
                n_l0 = i_square[r_s2_la.row][r_s2_lb.col];
                n_l1 = i_square[r_s2_lb.row][r_s2_la.col];
            end
        end
    end

    assign o_out_valid  = r_ob_v;
    assign o_out_letter = r_ob_sel ? r_ob_l1 : r_ob_l0;
    assign o_out_last   = r_ob_last && (!r_ob_two || r_ob_sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_ob_v   <= 1'b0;
            r_ob_sel <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_v <= i_job_valid;
            end
            if (w_s2_load) begin
                r_s2_v <= r_s1_v;
            end
            if (w_ob_free) begin
                r_ob_v   <= r_s2_v;
                r_ob_sel <= 1'b0;
            end else if (i_out_ready) begin
                r_ob_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1 <= i_job;
        end
        if (w_s2_load) begin
            r_s2_single <= r_s1.single;
            r_s2_last   <= r_s1.last;
            r_s2_a      <= w_a_m;
            r_s2_b      <= w_b_m;
            r_s2_la     <= pdc_pkg::locate(i_square, w_a_m);
            r_s2_lb     <= pdc_pkg::locate(i_square, w_b_m);
        end
        if (w_ob_free) begin
            r_ob_two  <= !r_s2_single;
            r_ob_last <= r_s2_last;
            r_ob_l0   <= n_l0;
            r_ob_l1   <= n_l1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_letter)))
        else $error("result letter changed while stalled");

    a_sel_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ob_v && r_ob_sel) |-> r_ob_two) else $error("second letter selected on single job");

    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_job_valid) else $error("pop without a queued job");

endmodule

// File: rtl/core/playfair_digraph_cipher.sv
// -----------------------------------------------------------------------------
// playfair_digraph_cipher
// Streaming Playfair cipher over a 5x5 key square held in write-only registers.
// -----------------------------------------------------------------------------
// Letters enter on the slave stream, one item per cycle while the four-entry
// job queue has room; an encrypt item that both splits a repeated letter and
// ends the text makes two jobs and holds the input low until the second is pushed.
// After a job leaves the queue it passes the stage 1 register, the stage 2
// lookup register and the output buffer before its first letter is valid on the
// master stream, and the back end sends one letter per cycle while the master
// stream is ready, so the output port at one letter per cycle sets the sustained rate.
// The user must write configuration only while no item is in flight; the block does not enforce it.
module playfair_digraph_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
    input  logic        s_axis_tlast,   // text_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] out_letter, [7:5] zero
    output logic        m_axis_tlast,   // run_last
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [59:0] i_cfg_data
);

    logic             r_mode;
    logic [59:0]      r_sq_first;
    logic [59:0]      r_sq_second;
    logic [4:0]       r_sq_final;

    pdc_pkg::t_square w_square;
    logic             w_push, w_full, w_pop, w_qvalid;
    pdc_pkg::t_job    w_push_job, w_pop_job;
    pdc_pkg::t_letter w_out_letter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_sq_first  <= '0;
            r_sq_second <= '0;
            r_sq_final  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pdc_pkg::CFG_MODE:      r_mode      <= i_cfg_data[0];
                pdc_pkg::CFG_SQ_FIRST:  r_sq_first  <= i_cfg_data;
                pdc_pkg::CFG_SQ_SECOND: r_sq_second <= i_cfg_data;
                pdc_pkg::CFG_SQ_FINAL:  r_sq_final  <= i_cfg_data[4:0];
                default:                r_mode      <= r_mode;
            endcase
        end
    end

    // Cell n sits at row n/5, column n%5.
    for (genvar n = 0; n < pdc_pkg::GRID * pdc_pkg::GRID; n++) begin : g_cell
        if (n < 12) begin : g_first
            assign w_square[n / pdc_pkg::GRID][n % pdc_pkg::GRID] = r_sq_first[5*n +: 5];
        end else if (n < 24) begin : g_second
            assign w_square[n / pdc_pkg::GRID][n % pdc_pkg::GRID] =
                r_sq_second[5*(n-12) +: 5];
        end else begin : g_final
            assign w_square[n / pdc_pkg::GRID][n % pdc_pkg::GRID] = r_sq_final;
        end
    end

    pdc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_letter   (s_axis_tdata[4:0]),
        .i_text_end (s_axis_tlast),
        .o_push     (w_push),
        .o_job      (w_push_job),
        .i_full     (w_full)
    );

    pdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_job   (w_pop_job)
    );

    pdc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_square     (w_square),
        .i_job_valid  (w_qvalid),
        .o_pop        (w_pop),
        .i_job        (w_pop_job),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_letter (w_out_letter),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, w_out_letter};

endmodule
